// ===== src/fpalu_pkg.sv =====
package fpalu_pkg;

	localparam int unsigned XLEN = 64;
	localparam int unsigned IMM_W = 16;
	localparam int unsigned SIGN_POS = XLEN - 1;
	localparam int unsigned HALF_SHIFT = 16;

	typedef enum logic [3:0] {
		OP_ADD       = 4'd0,
		OP_ADDC      = 4'd1,
		OP_ADDE      = 4'd2,
		OP_ADDME     = 4'd3,
		OP_ADDZE     = 4'd4,
		OP_ADDI      = 4'd5,
		OP_ADDIS     = 4'd6,
		OP_ADDIC     = 4'd7,
		OP_ADDIC_DOT = 4'd8,
		OP_AND       = 4'd9,
		OP_ANDC      = 4'd10,
		OP_ANDI_DOT  = 4'd11,
		OP_ANDIS_DOT = 4'd12
	} op_t;

	typedef logic [XLEN-1:0] word_t;

endpackage

// ===== src/fixed_point_add_logic_unit.sv =====
// An accepted item is registered into the first stage, which reads the register file, and its
// result is registered into the output stage once that stage is empty or being taken.
// Throughput: one item per cycle while the output is not stalled; the register file is read
// on acceptance, and the last write is forwarded so that dependent items follow back to back.
// Reset clears the pipeline valids, XER CA, OV, SO, the CR0 field and the
// per-register valid bits, so every register reads as zero until written.
module fixed_point_add_logic_unit #(
	parameter int unsigned NUM_REGS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [3:0]                    op,
	input  logic [$clog2(NUM_REGS)-1:0]   dest_reg,
	input  logic [$clog2(NUM_REGS)-1:0]   src_a_reg,
	input  logic [$clog2(NUM_REGS)-1:0]   src_b_reg,
	input  logic [fpalu_pkg::IMM_W-1:0]   imm16,
	input  logic                          oe_flag,
	input  logic                          rc_flag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fpalu_pkg::XLEN-1:0]    result,
	output logic                          carry,
	output logic                          overflow,
	output logic                          summary_overflow,
	output logic [3:0]                    cr0_field
);

	localparam int unsigned RegW = $clog2(NUM_REGS);
	localparam int unsigned XLEN = fpalu_pkg::XLEN;
	localparam int unsigned IMM_W = fpalu_pkg::IMM_W;

	fpalu_pkg::word_t rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;

	logic in_acc;
	logic s1_adv;

	logic s1_vld_s1;
	logic [3:0] op_s1;
	logic [RegW-1:0] dest_s1;
	logic [RegW-1:0] src_a_s1;
	logic [RegW-1:0] src_b_s1;
	logic [IMM_W-1:0] imm_s1;
	logic oe_s1;
	logic rc_s1;
	fpalu_pkg::word_t a_rd_s1;
	fpalu_pkg::word_t b_rd_s1;
	logic a_vld_s1;
	logic b_vld_s1;

	logic fwd_vld_q;
	logic [RegW-1:0] fwd_idx_q;
	fpalu_pkg::word_t fwd_data_q;

	logic ca_q;
	logic ov_q;
	logic so_q;
	logic [3:0] cr_q;

	logic out_vld_s2;
	fpalu_pkg::word_t result_s2;

	fpalu_pkg::word_t a_val;
	fpalu_pkg::word_t b_val;
	fpalu_pkg::word_t add_a;
	fpalu_pkg::word_t add_b;
	fpalu_pkg::word_t imm_sx;
	fpalu_pkg::word_t log_res;
	fpalu_pkg::word_t res;
	logic [XLEN:0] sum;
	logic cin;
	logic wr;
	logic use_oe;
	logic set_ca;
	logic rec_cr;
	logic is_logic;
	logic ovf;
	logic ov_upd;
	logic ca_n;
	logic ov_n;
	logic so_n;
	logic [3:0] cr_n;
	logic neg;
	logic zero;

	assign s1_adv = s1_vld_s1 && (!out_vld_s2 || !out_stall);
	assign in_stall = s1_vld_s1 && !s1_adv;
	assign in_acc = in_valid && !in_stall;

	always_comb begin
		a_val = (fwd_vld_q && fwd_idx_q == src_a_s1) ? fwd_data_q :
			(a_vld_s1 ? a_rd_s1 : '0);
		b_val = (fwd_vld_q && fwd_idx_q == src_b_s1) ? fwd_data_q :
			(b_vld_s1 ? b_rd_s1 : '0);
		imm_sx = {{(XLEN-IMM_W){imm_s1[IMM_W-1]}}, imm_s1};
		add_a = a_val;
		add_b = '0;
		cin = 1'b0;
		wr = 1'b1;
		use_oe = 1'b0;
		set_ca = 1'b0;
		rec_cr = 1'b0;
		is_logic = 1'b0;
		log_res = '0;
		unique case (fpalu_pkg::op_t'(op_s1))
			fpalu_pkg::OP_ADD: begin
				add_b = b_val;
				use_oe = 1'b1;
				rec_cr = rc_s1;
			end
			fpalu_pkg::OP_ADDC: begin
				add_b = b_val;
				use_oe = 1'b1;
				set_ca = 1'b1;
				rec_cr = rc_s1;
			end
			fpalu_pkg::OP_ADDE: begin
				add_b = b_val;
				cin = ca_q;
				use_oe = 1'b1;
				set_ca = 1'b1;
				rec_cr = rc_s1;
			end
			fpalu_pkg::OP_ADDME: begin
				add_b = '1;
				cin = ca_q;
				use_oe = 1'b1;
				set_ca = 1'b1;
				rec_cr = rc_s1;
			end
			fpalu_pkg::OP_ADDZE: begin
				cin = ca_q;
				use_oe = 1'b1;
				set_ca = 1'b1;
				rec_cr = rc_s1;
			end
			fpalu_pkg::OP_ADDI: begin
				if (src_a_s1 == '0) begin
					add_a = '0;
				end
				add_b = imm_sx;
			end
			fpalu_pkg::OP_ADDIS: begin
				if (src_a_s1 == '0) begin
					add_a = '0;
				end
				add_b = {imm_sx[XLEN-1-fpalu_pkg::HALF_SHIFT:0],
					{fpalu_pkg::HALF_SHIFT{1'b0}}};
			end
			fpalu_pkg::OP_ADDIC: begin
				add_b = imm_sx;
				set_ca = 1'b1;
			end
			fpalu_pkg::OP_ADDIC_DOT: begin
				add_b = imm_sx;
				set_ca = 1'b1;
				rec_cr = 1'b1;
			end
			fpalu_pkg::OP_AND: begin
				is_logic = 1'b1;
				log_res = a_val & b_val;
				rec_cr = rc_s1;
			end
			fpalu_pkg::OP_ANDC: begin
				is_logic = 1'b1;
				log_res = a_val & ~b_val;
				rec_cr = rc_s1;
			end
			fpalu_pkg::OP_ANDI_DOT: begin
				is_logic = 1'b1;
				log_res = a_val & {{(XLEN-IMM_W){1'b0}}, imm_s1};
				rec_cr = 1'b1;
			end
			fpalu_pkg::OP_ANDIS_DOT: begin
				is_logic = 1'b1;
				log_res = a_val & {{(XLEN-IMM_W-fpalu_pkg::HALF_SHIFT){1'b0}}, imm_s1,
					{fpalu_pkg::HALF_SHIFT{1'b0}}};
				rec_cr = 1'b1;
			end
			default: begin
				wr = 1'b0;
			end
		endcase
		sum = {1'b0, add_a} + {1'b0, add_b} + {{XLEN{1'b0}}, cin};
		ovf = ~(add_a[fpalu_pkg::SIGN_POS] ^ add_b[fpalu_pkg::SIGN_POS]) &
			(add_a[fpalu_pkg::SIGN_POS] ^ sum[fpalu_pkg::SIGN_POS]);
		if (!wr) begin
			res = '0;
		end else if (is_logic) begin
			res = log_res;
		end else begin
			res = sum[XLEN-1:0];
		end
		ov_upd = wr && use_oe && oe_s1;
		ca_n = set_ca ? sum[XLEN] : ca_q;
		ov_n = ov_upd ? ovf : ov_q;
		so_n = so_q || (ov_upd && ovf);
		neg = res[fpalu_pkg::SIGN_POS];
		zero = (res == '0);
		cr_n = (wr && rec_cr) ? {neg, !neg && !zero, zero, so_n} : cr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
			out_vld_s2 <= 1'b0;
			fwd_vld_q <= 1'b0;
			rf_vld_q <= '0;
			ca_q <= 1'b0;
			ov_q <= 1'b0;
			so_q <= 1'b0;
			cr_q <= '0;
		end else begin
			if (in_acc) begin
				s1_vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_vld_s2 <= 1'b1;
				ca_q <= ca_n;
				ov_q <= ov_n;
				so_q <= so_n;
				cr_q <= cr_n;
				if (wr) begin
					fwd_vld_q <= 1'b1;
					rf_vld_q[dest_s1] <= 1'b1;
				end
			end else if (!out_stall) begin
				out_vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1 <= op;
			dest_s1 <= dest_reg;
			src_a_s1 <= src_a_reg;
			src_b_s1 <= src_b_reg;
			imm_s1 <= imm16;
			oe_s1 <= oe_flag;
			rc_s1 <= rc_flag;
			a_rd_s1 <= rf_mem[src_a_reg];
			b_rd_s1 <= rf_mem[src_b_reg];
			a_vld_s1 <= rf_vld_q[src_a_reg];
			b_vld_s1 <= rf_vld_q[src_b_reg];
		end
		if (s1_adv) begin
			result_s2 <= res;
			if (wr) begin
				rf_mem[dest_s1] <= res;
				fwd_idx_q <= dest_s1;
				fwd_data_q <= res;
			end
		end
	end

	assign out_valid = out_vld_s2;
	assign result = result_s2;
	assign carry = ca_q;
	assign overflow = ov_q;
	assign summary_overflow = so_q;
	assign cr0_field = cr_q;

	assert property (@(posedge clk) disable iff (!arst_n) so_q |=> so_q)
		else $error("Summary overflow was cleared after being set.");

	assert property (@(posedge clk) disable iff (!arst_n) ov_q |-> so_q)
		else $error("Overflow is set without summary overflow.");

	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> s1_vld_s1)
		else $error("Input stalled with an empty first stage.");

	assert property (@(posedge clk) disable iff (!arst_n) s1_adv |=> out_vld_s2)
		else $error("An advancing item did not reach the output register.");

endmodule

// ===== verif/fpalu_result_check.sv =====
`timescale 1ns / 100ps

module fpalu_result_check #(
	parameter int unsigned NUM_REGS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [3:0]                    op,
	input  logic [$clog2(NUM_REGS)-1:0]   dest_reg,
	input  logic [$clog2(NUM_REGS)-1:0]   src_a_reg,
	input  logic [$clog2(NUM_REGS)-1:0]   src_b_reg,
	input  logic [fpalu_pkg::IMM_W-1:0]   imm16,
	input  logic                          oe_flag,
	input  logic                          rc_flag,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [fpalu_pkg::XLEN-1:0]    result,
	input  logic                          carry,
	input  logic                          overflow,
	input  logic                          summary_overflow,
	input  logic [3:0]                    cr0_field,
	output int unsigned                   mismatches,
	output int unsigned                   pending
);

	localparam int unsigned XLEN = fpalu_pkg::XLEN;
	localparam int unsigned IMM_W = fpalu_pkg::IMM_W;
	localparam int unsigned SIGN_POS = fpalu_pkg::SIGN_POS;
	localparam logic [3:0] CR_LT = 4'b1000;
	localparam logic [3:0] CR_GT = 4'b0100;
	localparam logic [3:0] CR_EQ = 4'b0010;

	typedef logic [$clog2(NUM_REGS)-1:0] reg_idx_t;

	typedef struct {
		fpalu_pkg::word_t value;
		logic       ca;
		logic       ov;
		logic       so;
		logic [3:0] cr;
	} outcome_t;

	fpalu_pkg::word_t gpr [NUM_REGS];
	logic       xer_ca;
	logic       xer_ov;
	logic       xer_so;
	logic       [3:0] cr0;
	outcome_t   due_results [$];

	task automatic execute_insn(input logic [3:0] opc, input reg_idx_t rd, input reg_idx_t ra,
			input reg_idx_t rb, input logic [IMM_W-1:0] imm, input logic oe, input logic rc);
		fpalu_pkg::word_t a;
		fpalu_pkg::word_t addend;
		fpalu_pkg::word_t simm;
		fpalu_pkg::word_t d;
		logic [XLEN:0] sum;
		logic       cin;
		logic       co;
		logic       vo;
		logic       arith;
		logic       wr;
		logic       use_oe;
		logic       use_rc;
		logic       rc_eff;
		logic       set_ca;
		logic [3:0] sign_bits;
		a = gpr[ra];
		simm = {{(XLEN - IMM_W){imm[IMM_W-1]}}, imm};
		addend = gpr[rb];
		cin = 1'b0;
		d = '0;
		co = 1'b0;
		vo = 1'b0;
		arith = 1'b1;
		wr = 1'b1;
		use_oe = 1'b0;
		use_rc = 1'b0;
		rc_eff = rc;
		set_ca = 1'b0;
		case (opc)
			fpalu_pkg::OP_ADD: begin
				use_oe = 1'b1;
				use_rc = 1'b1;
			end
			fpalu_pkg::OP_ADDC: begin
				use_oe = 1'b1;
				use_rc = 1'b1;
				set_ca = 1'b1;
			end
			fpalu_pkg::OP_ADDE: begin
				cin = xer_ca;
				use_oe = 1'b1;
				use_rc = 1'b1;
				set_ca = 1'b1;
			end
			fpalu_pkg::OP_ADDME: begin
				addend = '1;
				cin = xer_ca;
				use_oe = 1'b1;
				use_rc = 1'b1;
				set_ca = 1'b1;
			end
			fpalu_pkg::OP_ADDZE: begin
				addend = '0;
				cin = xer_ca;
				use_oe = 1'b1;
				use_rc = 1'b1;
				set_ca = 1'b1;
			end
			fpalu_pkg::OP_ADDI: begin
				if (ra == '0) a = '0;
				addend = simm;
			end
			fpalu_pkg::OP_ADDIS: begin
				if (ra == '0) a = '0;
				addend = simm << fpalu_pkg::HALF_SHIFT;
			end
			fpalu_pkg::OP_ADDIC: begin
				addend = simm;
				set_ca = 1'b1;
			end
			fpalu_pkg::OP_ADDIC_DOT: begin
				addend = simm;
				set_ca = 1'b1;
				use_rc = 1'b1;
				rc_eff = 1'b1;
			end
			fpalu_pkg::OP_AND: begin
				arith = 1'b0;
				d = a & gpr[rb];
				use_rc = 1'b1;
			end
			fpalu_pkg::OP_ANDC: begin
				arith = 1'b0;
				d = a & ~gpr[rb];
				use_rc = 1'b1;
			end
			fpalu_pkg::OP_ANDI_DOT: begin
				arith = 1'b0;
				d = a & fpalu_pkg::word_t'(imm);
				use_rc = 1'b1;
				rc_eff = 1'b1;
			end
			fpalu_pkg::OP_ANDIS_DOT: begin
				arith = 1'b0;
				d = a & (fpalu_pkg::word_t'(imm) << fpalu_pkg::HALF_SHIFT);
				use_rc = 1'b1;
				rc_eff = 1'b1;
			end
			default: begin
				arith = 1'b0;
				wr = 1'b0;
			end
		endcase
		if (arith) begin
			sum = {1'b0, a} + {1'b0, addend} + {{XLEN{1'b0}}, cin};
			d = sum[XLEN-1:0];
			co = sum[XLEN];
			vo = ~(a[SIGN_POS] ^ addend[SIGN_POS]) & (a[SIGN_POS] ^ d[SIGN_POS]);
		end
		if (wr) begin
			gpr[rd] = d;
			if (use_oe && oe) begin
				xer_ov = vo;
				if (vo) xer_so = 1'b1;
			end
			if (set_ca) xer_ca = co;
			if (use_rc && rc_eff) begin
				if (d == '0) sign_bits = CR_EQ;
				else if (d[SIGN_POS]) sign_bits = CR_LT;
				else sign_bits = CR_GT;
				cr0 = sign_bits | {3'b000, xer_so};
			end
		end
		due_results.push_back('{value: d, ca: xer_ca, ov: xer_ov, so: xer_so, cr: cr0});
	endtask

	task automatic report_mismatch(input string field, input fpalu_pkg::word_t got,
			input fpalu_pkg::word_t want);
		$display("%0t ns: %s is %h, expected %h", $realtime, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		outcome_t want;
		if (!arst_n) begin
			foreach (gpr[i]) gpr[i] = '0;
			xer_ca = 1'b0;
			xer_ov = 1'b0;
			xer_so = 1'b0;
			cr0 = '0;
			due_results.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				execute_insn(op, dest_reg, src_a_reg, src_b_reg, imm16, oe_flag, rc_flag);
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with no item due", result, '0);
				end else begin
					want = due_results.pop_front();
					if (result !== want.value) report_mismatch("result", result, want.value);
					if (carry !== want.ca)
						report_mismatch("carry", fpalu_pkg::word_t'(carry),
							fpalu_pkg::word_t'(want.ca));
					if (overflow !== want.ov)
						report_mismatch("overflow", fpalu_pkg::word_t'(overflow),
							fpalu_pkg::word_t'(want.ov));
					if (summary_overflow !== want.so)
						report_mismatch("summary_overflow",
							fpalu_pkg::word_t'(summary_overflow),
							fpalu_pkg::word_t'(want.so));
					if (cr0_field !== want.cr)
						report_mismatch("cr0_field", fpalu_pkg::word_t'(cr0_field),
							fpalu_pkg::word_t'(want.cr));
				end
			end
			pending <= due_results.size();
		end
	end

endmodule

// ===== verif/fixed_point_add_logic_unit_test.sv =====
`timescale 1ns / 100ps

module fixed_point_add_logic_unit_test;

	localparam int unsigned NUM_REGS = 32;
	localparam int unsigned REG_W = $clog2(NUM_REGS);
	localparam int unsigned IMM_W = fpalu_pkg::IMM_W;
	localparam int unsigned ITEMS_TARGET = 1800;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned MAX_WAIT = 11;
	localparam logic [3:0] OP_CODE_TOP = '1;

	typedef logic [REG_W-1:0] reg_idx_t;
	typedef logic [IMM_W-1:0] imm_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [3:0]                    op;
	logic [REG_W-1:0]              dest_reg;
	logic [REG_W-1:0]              src_a_reg;
	logic [REG_W-1:0]              src_b_reg;
	logic [IMM_W-1:0]              imm16;
	logic                          oe_flag;
	logic                          rc_flag;
	logic                          out_valid;
	logic                          out_stall;
	logic [fpalu_pkg::XLEN-1:0]    result;
	logic                          carry;
	logic                          overflow;
	logic                          summary_overflow;
	logic [3:0]                    cr0_field;
	int unsigned                   mismatches;
	int unsigned                   pending;

	int unsigned items_sent;
	int unsigned cycles;
	bit          send_burst;
	bit          recv_burst;

	fixed_point_add_logic_unit #(
		.NUM_REGS(NUM_REGS)
	) u_top (.*);

	fpalu_result_check #(
		.NUM_REGS(NUM_REGS)
	) u_result_check (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic issue(input logic [3:0] opc, input int unsigned rd, input int unsigned ra,
			input int unsigned rb, input logic [IMM_W-1:0] imm, input logic oe, input logic rc);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= opc;
		dest_reg <= reg_idx_t'(rd);
		src_a_reg <= reg_idx_t'(ra);
		src_b_reg <= reg_idx_t'(rb);
		imm16 <= imm;
		oe_flag <= oe;
		rc_flag <= rc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Builds a full-width value in one register: immediate loads separated by sixteen
	// self-additions, each of which shifts the register up by one bit (adde also adds the carry).
	task automatic load_wide_value();
		int unsigned rd;
		rd = $urandom_range(1, NUM_REGS - 1);
		issue(fpalu_pkg::OP_ADDIS, rd, 0, $urandom_range(0, NUM_REGS - 1), imm_t'($urandom),
			1'($urandom), 1'($urandom));
		for (int k = 0; k < 2; k++) begin
			repeat (fpalu_pkg::HALF_SHIFT)
				issue(4'($urandom_range(fpalu_pkg::OP_ADD, fpalu_pkg::OP_ADDE)), rd, rd, rd,
					imm_t'($urandom), 1'($urandom), 1'($urandom));
			issue(fpalu_pkg::OP_ADDIS, rd, rd, $urandom_range(0, NUM_REGS - 1),
				imm_t'($urandom), 1'($urandom), 1'($urandom));
		end
		issue(fpalu_pkg::OP_ADDI, rd, rd, $urandom_range(0, NUM_REGS - 1), imm_t'($urandom),
			1'($urandom), 1'($urandom));
	endtask

	task automatic random_item();
		logic [3:0]       opc;
		logic [IMM_W-1:0] imm;
		if ($urandom_range(0, 99) < 5)
			opc = 4'($urandom_range(int'(fpalu_pkg::OP_ANDIS_DOT) + 1, int'(OP_CODE_TOP)));
		else
			opc = 4'($urandom_range(fpalu_pkg::OP_ADD, fpalu_pkg::OP_ANDIS_DOT));
		case ($urandom_range(0, 9))
			0: imm = '0;
			1: imm = '1;
			2: imm = {1'b1, {(IMM_W - 1){1'b0}}};
			3: imm = {1'b0, {(IMM_W - 1){1'b1}}};
			default: imm = imm_t'($urandom);
		endcase
		issue(opc, $urandom_range(0, NUM_REGS - 1), $urandom_range(0, NUM_REGS - 1),
			$urandom_range(0, NUM_REGS - 1), imm, 1'($urandom), 1'($urandom));
	endtask

	// The receiving side holds off for a random number of cycles before each
	// result, with stretches in which it never holds off at all.
	initial begin : drain_results
		int unsigned hold;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
			hold = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		op <= fpalu_pkg::OP_ADD;
		dest_reg <= '0;
		src_a_reg <= '0;
		src_b_reg <= '0;
		imm16 <= '0;
		oe_flag <= 1'b0;
		rc_flag <= 1'b0;
		items_sent = 0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Register zero reads as zero for addi and addis, so these load constants.
		issue(fpalu_pkg::OP_ADDI, 1, 0, 0, 16'hffff, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ADDI, 2, 0, 0, 16'h0001, 1'b0, 1'b0);
		issue(fpalu_pkg::OP_ADDIS, 3, 0, 0, 16'h8000, 1'b0, 1'b1);
		issue(fpalu_pkg::OP_ADDIS, 4, 31, 31, 16'h7fff, 1'b1, 1'b0);
		// Plain add leaves the carry alone; the carrying forms set it.
		issue(fpalu_pkg::OP_ADD, 5, 1, 2, 16'h0000, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ADDC, 5, 1, 2, 16'h0000, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ADDE, 6, 1, 0, 16'h0000, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ADDME, 7, 2, 0, 16'h0000, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ADDME, 7, 0, 0, 16'h0000, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ADDZE, 8, 1, 0, 16'h0000, 1'b0, 1'b1);
		issue(fpalu_pkg::OP_ADDZE, 8, 3, 0, 16'h0000, 1'b1, 1'b0);
		issue(fpalu_pkg::OP_ADDME, 9, 0, 0, 16'h0000, 1'b1, 1'b1);
		// Once register zero holds a value, only addi and addis still see zero.
		issue(fpalu_pkg::OP_ADDIC, 0, 1, 0, 16'h0005, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ADDI, 10, 0, 0, 16'h7fff, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ADDIS, 11, 0, 0, 16'hffff, 1'b0, 1'b0);
		issue(fpalu_pkg::OP_ADD, 12, 0, 2, 16'h0000, 1'b0, 1'b0);
		issue(fpalu_pkg::OP_ADDIC_DOT, 13, 3, 0, 16'h8000, 1'b1, 1'b0);
		issue(fpalu_pkg::OP_AND, 14, 1, 3, 16'h0000, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ANDC, 15, 1, 3, 16'h0000, 1'b1, 1'b1);
		issue(fpalu_pkg::OP_ANDI_DOT, 16, 1, 0, 16'hffff, 1'b0, 1'b0);
		issue(fpalu_pkg::OP_ANDIS_DOT, 17, 3, 0, 16'h8000, 1'b1, 1'b0);
		issue(fpalu_pkg::OP_ANDI_DOT, 31, 2, 31, 16'h0000, 1'b0, 1'b1);
		// Unused codes change nothing.
		issue(4'(int'(fpalu_pkg::OP_ANDIS_DOT) + 1), 1, 1, 2, 16'hffff, 1'b1, 1'b1);
		issue(OP_CODE_TOP, 2, 31, 31, 16'h0000, 1'b1, 1'b1);

		while (items_sent < ITEMS_TARGET) begin
			if ($urandom_range(0, 99) < 6)
				load_wide_value();
			else
				random_item();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
